>>> rtl/rcpfd_pkg.sv
// rcpfd_pkg: shared codes and types of the rc pulse frame decoder
// pulse class codes, register indexes, sequencer states and stream widths
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package rcpfd_pkg;

  // pulse class codes
  localparam logic [1:0] CLS_ZERO    = 2'd0;
  localparam logic [1:0] CLS_ONE     = 2'd1;
  localparam logic [1:0] CLS_SYNC    = 2'd2;
  localparam logic [1:0] CLS_INVALID = 2'd3;

  // configuration register indexes (word address)
  localparam logic REG_LOW_PASS    = 1'b0;
  localparam logic REG_SYNC_FACTOR = 1'b1;

  // stream payload layout
  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 72;
  localparam int CLASS_LSB   = 64;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CALC,
    ST_CLASS,
    ST_RD_A,
    ST_RD_B,
    ST_RD_W
  } state_t;

endpackage

`default_nettype wire

>>> rtl/rcpfd_ram.sv
// rcpfd_ram: generic single-write, single-read ram with registered read
// depends on nothing
`timescale 1ns / 1ps
`default_nettype none

module rcpfd_ram #(
  parameter int WIDTH = 34,
  parameter int DEPTH = 50
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

>>> rtl/rc_pulse_frame_decoder_core.sv
// rc_pulse_frame_decoder_core: edge timestamps in, classified pulse pairs of a frame out
// depends on rcpfd_pkg and rcpfd_ram (pulse/class ring)
//
//   channel  dir  handshake              payload
//   s_*      in   s_tvalid / s_tready    s_tdata: edge_time
//   m_*      out  m_tvalid / m_tready    m_tdata: first_pulse, second_pulse, bit_class;
//                                        m_tlast: frame_end
//   apb      in   psel/penable/pwrite    paddr[2] selects glitch limit or sync multiple
//
// an edge passes ST_IDLE and ST_CALC, then ST_CLASS if a pulse is classified and
//   written to the ring; a completed frame adds readout in ST_RD_A, then ST_RD_B and
//   ST_RD_W per result (one ring read port, two entries each); output stalls lengthen it
// one edge is in work at a time; s_tready is high only while the sequencer is idle
// reset is synchronous; the ring is not cleared, a frame is only sent once it is full
`timescale 1ns / 1ps
`default_nettype none

module rc_pulse_frame_decoder_core #(
  parameter int FRAME_BITS = 25
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  // edge stream
  input  wire logic                                s_tvalid,
  output logic                                     s_tready,
  input  wire logic [rcpfd_pkg::IN_TDATA_W-1:0]    s_tdata,   // [31:0] edge_time
  // result stream
  output logic                                     m_tvalid,
  input  wire logic                                m_tready,
  output logic      [rcpfd_pkg::OUT_TDATA_W-1:0]   m_tdata,   // [31:0] first_pulse,
                                                              // [63:32] second_pulse,
                                                              // [65:64] bit_class, zero pad
  output logic                                     m_tlast,   // frame_end
  // configuration
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic [2:0]                          paddr,
  input  wire logic [31:0]                         pwdata,
  output logic      [31:0]                         prdata,
  output logic                                     pready
);

  import rcpfd_pkg::*;

  localparam int RING_LEN = 2 * FRAME_BITS;
  localparam int AW       = $clog2(RING_LEN);
  localparam int BW       = $clog2(FRAME_BITS);
  localparam logic [AW-1:0] RING_LAST = AW'(RING_LEN - 1);
  localparam logic [BW-1:0] BIT_LAST  = BW'(FRAME_BITS - 1);

  // configuration registers
  logic [15:0] glitch_limit;
  logic [7:0]  sync_mult;

  // control state
  state_t              state, state_next;
  logic [31:0]         prior_edge;
  logic [31:0]         pending_pulse;
  logic                merge_next;
  logic [31:0]         recent_pulses [3];
  logic [RING_LEN-1:0] match_chain, match_chain_next;
  logic [AW-1:0]       ring_pos;
  logic [AW-1:0]       rd_ptr;
  logic [BW-1:0]       bit_cnt;

  // work registers
  logic [31:0] edge_q;
  logic [31:0] pulse_q;
  logic [39:0] prod_q;
  logic [32:0] plen_q;
  logic [31:0] first_q;

  // output register
  logic        out_valid;
  logic [31:0] out_first;
  logic [31:0] out_second;
  logic [1:0]  out_class;
  logic        out_last;

  // ring port
  logic           ram_we;
  logic           ram_re;
  logic [33:0]    ram_rdata;
  logic [1:0]     cls;

  // datapath
  logic [31:0] dur;
  logic        is_glitch;
  logic        take;
  logic [32:0] blen;
  logic [34:0] blen3;
  logic [33:0] blen2;
  logic [34:0] plen3;
  logic [33:0] plen2;
  logic        len_ok;
  logic        is_data;
  logic        out_free;
  logic        load_out;
  logic        cfg_wr;

  rcpfd_ram #(
    .WIDTH (34),
    .DEPTH (RING_LEN)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ring_pos),
    .wdata ({cls, pulse_q}),
    .re    (ram_re),
    .raddr (rd_ptr),
    .rdata (ram_rdata)
  );

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_comb begin
    case (paddr[2])
      REG_LOW_PASS:    prdata = {16'd0, glitch_limit};
      REG_SYNC_FACTOR: prdata = {24'd0, sync_mult};
      default:         prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      glitch_limit <= 16'd100;
      sync_mult    <= 8'd4;
    end else if (cfg_wr) begin
      case (paddr[2])
        REG_LOW_PASS:    glitch_limit <= pwdata[15:0];
        REG_SYNC_FACTOR: sync_mult    <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // edge front end
  assign dur       = edge_q - prior_edge;
  assign is_glitch = dur < {16'd0, glitch_limit};
  assign take      = (prior_edge != 32'd0) && !is_glitch && !merge_next &&
                     (pending_pulse != 32'd0);

  // classification against the previous pulse
  always_comb begin
    if (prod_q < {8'd0, pulse_q}) begin
      cls = CLS_SYNC;
    end else if (recent_pulses[0] < pulse_q) begin
      cls = CLS_ZERO;
    end else if (recent_pulses[0] > pulse_q) begin
      cls = CLS_ONE;
    end else begin
      cls = CLS_INVALID;
    end
  end

  // bit length within a factor of 1.5 of the previous one
  assign blen    = {1'b0, recent_pulses[0]} + {1'b0, pulse_q};
  assign blen2   = {blen, 1'b0};
  assign blen3   = {2'b00, blen} + {1'b0, blen2};
  assign plen2   = {plen_q, 1'b0};
  assign plen3   = {2'b00, plen_q} + {1'b0, plen2};
  assign len_ok  = (blen3 > {1'b0, plen2}) && ({1'b0, blen2} < plen3);
  assign is_data = (cls == CLS_ZERO) || (cls == CLS_ONE);

  always_comb begin
    match_chain_next[0] = 1'b1;
    for (int i = 1; i < RING_LEN; i++) begin
      if ((i % 2) == 0) begin
        match_chain_next[i] = match_chain[i-1];
      end else if (i != RING_LEN - 1) begin
        match_chain_next[i] = match_chain[i-1] && (i == 1 || len_ok) && is_data;
      end else begin
        match_chain_next[i] = match_chain[i-1] && (cls == CLS_SYNC);
      end
    end
  end

  assign out_free = !out_valid || m_tready;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:  if (s_tvalid) state_next = ST_CALC;
      ST_CALC:  state_next = take ? ST_CLASS : ST_IDLE;
      ST_CLASS: state_next = match_chain_next[RING_LEN-1] ? ST_RD_A : ST_IDLE;
      ST_RD_A:  state_next = ST_RD_B;
      ST_RD_B:  state_next = ST_RD_W;
      ST_RD_W: begin
        if (out_free) begin
          state_next = (bit_cnt == BIT_LAST) ? ST_IDLE : ST_RD_B;
        end
      end
      default:  state_next = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    s_tready = 1'b0;
    ram_we   = 1'b0;
    ram_re   = 1'b0;
    load_out = 1'b0;
    case (state)
      ST_IDLE:  s_tready = 1'b1;
      ST_CLASS: ram_we = 1'b1;
      ST_RD_A:  ram_re = 1'b1;
      ST_RD_B:  ram_re = 1'b1;
      ST_RD_W: begin
        load_out = out_free;
        // fetch the next first pulse while handing over this result
        ram_re   = out_free && (bit_cnt != BIT_LAST);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= ST_IDLE;
      prior_edge       <= 32'd0;
      pending_pulse    <= 32'd0;
      merge_next       <= 1'b0;
      recent_pulses[0] <= 32'd0;
      recent_pulses[1] <= 32'd0;
      recent_pulses[2] <= 32'd0;
      match_chain      <= '0;
      ring_pos         <= '0;
      rd_ptr           <= '0;
      bit_cnt          <= '0;
      out_valid        <= 1'b0;
    end else begin
      state <= state_next;

      if (state == ST_CALC) begin
        prior_edge <= edge_q;
        if (prior_edge != 32'd0) begin
          if (is_glitch) begin
            pending_pulse <= pending_pulse + dur;
            merge_next    <= 1'b1;
          end else if (merge_next) begin
            pending_pulse <= pending_pulse + dur;
            merge_next    <= 1'b0;
          end else begin
            pending_pulse <= dur;
          end
        end
      end

      if (state == ST_CLASS) begin
        match_chain      <= match_chain_next;
        recent_pulses[0] <= pulse_q;
        recent_pulses[1] <= recent_pulses[0];
        recent_pulses[2] <= recent_pulses[1];
        ring_pos         <= (ring_pos == RING_LAST) ? '0 : ring_pos + 1'b1;
        // readout starts at the oldest entry, which is the next write slot
        rd_ptr           <= (ring_pos == RING_LAST) ? '0 : ring_pos + 1'b1;
        bit_cnt          <= '0;
      end

      if (ram_re) begin
        rd_ptr <= (rd_ptr == RING_LAST) ? '0 : rd_ptr + 1'b1;
      end

      if (load_out) begin
        bit_cnt <= bit_cnt + 1'b1;
      end

      if (load_out) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && s_tvalid) begin
      edge_q <= s_tdata;
    end
    if (state == ST_CALC) begin
      pulse_q <= pending_pulse;
      prod_q  <= {32'd0, sync_mult} * {8'd0, recent_pulses[0]};
      plen_q  <= {1'b0, recent_pulses[1]} + {1'b0, recent_pulses[2]};
    end
    if (state == ST_RD_B) begin
      first_q <= ram_rdata[31:0];
    end
    if (load_out) begin
      out_first  <= first_q;
      out_second <= ram_rdata[31:0];
      out_class  <= ram_rdata[33:32];
      out_last   <= (bit_cnt == BIT_LAST);
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {6'd0, out_class, out_second, out_first};
  assign m_tlast  = out_last;

endmodule

`default_nettype wire

>>> rtl/rcpfd_checker.sv
// rcpfd_checker: port-level assertions for rc_pulse_frame_decoder_core
// depends on rcpfd_pkg; bound to the top level at the end of this file
`timescale 1ns / 1ps
`default_nettype none

module rcpfd_checker (
  input wire logic                                clk,
  input wire logic                                rst,
  input wire logic                                s_tvalid,
  input wire logic                                s_tready,
  input wire logic                                m_tvalid,
  input wire logic                                m_tready,
  input wire logic [rcpfd_pkg::OUT_TDATA_W-1:0]   m_tdata,
  input wire logic                                m_tlast
);

  import rcpfd_pkg::*;

  // a held result beat keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("result beat changed while stalled");

  // one edge at a time: after taking a beat the input closes
  a_in_single: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("second edge taken while the first is in work");

  // mid-frame the decoder takes no edges
  a_frame_busy: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tlast |-> !s_tready)
    else $error("edge taken in the middle of a frame readout");

  // a frame closes on a sync bit
  a_last_sync: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast |-> m_tdata[CLASS_LSB+1:CLASS_LSB] == CLS_SYNC)
    else $error("frame end without sync class");

endmodule

bind rc_pulse_frame_decoder_core rcpfd_checker u_rcpfd_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);

`default_nettype wire
